// File: design/upc_pkg.sv
// Shared types and constants for the URL percent codec.
package upc_pkg;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // codec_mode register values
   localparam logic [1:0] MODE_DECODE = 2'd0;
   localparam logic [1:0] MODE_FORM   = 2'd1;

   // characters of interest
   localparam logic [7:0] CH_PCT     = 8'h25;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_UNDER   = 8'h5F;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_TILDE   = 8'h7E;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_AMP     = 8'h26;
   localparam logic [7:0] CH_EQUAL   = 8'h3D;
   localparam logic [7:0] CH_QUEST   = 8'h3F;
   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_UC_A    = 8'h41;
   localparam logic [7:0] CH_UC_Z    = 8'h5A;
   localparam logic [7:0] CH_LC_A    = 8'h61;
   localparam logic [7:0] CH_LC_Z    = 8'h7A;
   localparam logic [7:0] CH_DIG_0   = 8'h30;
   localparam logic [7:0] CH_DIG_9   = 8'h39;

   // offsets from character code to digit value
   localparam logic [7:0] OFS_UPPER  = 8'd55;
   localparam logic [7:0] OFS_LOWER  = 8'd87;
   localparam logic [7:0] OFS_DIGIT  = 8'd48;
   localparam logic [5:0] BAD_LOW    = 6'h20;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_PCT,
      PH_DIGIT
   } upc_phase_type;

   // one queued transaction: up to three result bytes
   typedef struct packed {
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
      logic [1:0] count;
      logic       last;
   } upc_entry_type;

endpackage

// File: design/upc_front.sv
// Front end: accepts source bytes, tracks escapes and forms result groups.
module upc_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_in_byte,
   input  logic                   req_msg_last,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_data,
   input  logic                   q_full,
   output logic                   q_push,
   output upc_pkg::upc_entry_type q_entry
);

   upc_pkg::upc_phase_type phase_ff, phase_in;
   logic [5:0]             high_ff, high_in;
   logic [1:0]             mode_ff, mode_in;
   logic                   accept;
   logic                   csr_write;
   logic                   dig_ok;
   logic [5:0]             dig_val;
   logic [5:0]             hi_new;
   logic                   pass;
   upc_pkg::upc_entry_type ent;

   function automatic logic [7:0] combine(input logic [5:0] hi, input logic [5:0] lo);
      combine = {hi[3:0], 4'b0000} + {2'b00, lo};
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      hex_char = (v > 4'd9) ? ({4'b0000, v} + upc_pkg::OFS_UPPER)
                            : ({4'b0000, v} + upc_pkg::OFS_DIGIT);
   endfunction

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;
   assign req_stall = q_full;
   assign accept    = req_valid & ~req_stall;

   // digit classification
   always_comb begin
      logic [7:0] d;
      d      = 8'd0;
      dig_ok = 1'b1;
      if (req_in_byte inside {[upc_pkg::CH_UC_A : upc_pkg::CH_UC_Z]}) begin
         d = req_in_byte - upc_pkg::OFS_UPPER;
      end else if (req_in_byte inside {[upc_pkg::CH_LC_A : upc_pkg::CH_LC_Z]}) begin
         d = req_in_byte - upc_pkg::OFS_LOWER;
      end else if (req_in_byte inside {[upc_pkg::CH_DIG_0 : upc_pkg::CH_DIG_9]}) begin
         d = req_in_byte - upc_pkg::OFS_DIGIT;
      end else begin
         dig_ok = 1'b0;
      end
      dig_val = d[5:0];
   end

   assign hi_new = dig_ok ? dig_val : 6'd0;

   always_comb begin
      pass = (req_in_byte inside {[upc_pkg::CH_UC_A : upc_pkg::CH_UC_Z],
                                  [upc_pkg::CH_LC_A : upc_pkg::CH_LC_Z],
                                  [upc_pkg::CH_DIG_0 : upc_pkg::CH_DIG_9],
                                  upc_pkg::CH_MINUS, upc_pkg::CH_UNDER,
                                  upc_pkg::CH_DOT, upc_pkg::CH_TILDE});
      if (mode_ff == upc_pkg::MODE_FORM) begin
         pass = pass | (req_in_byte == upc_pkg::CH_PCT);
      end else begin
         pass = pass | (req_in_byte inside {upc_pkg::CH_SLASH, upc_pkg::CH_AMP,
                                            upc_pkg::CH_EQUAL, upc_pkg::CH_QUEST,
                                            upc_pkg::CH_HASH});
      end
   end

   // next state
   always_comb begin
      phase_in = phase_ff;
      high_in  = high_ff;
      mode_in  = mode_ff;
      if (csr_write) begin
         mode_in  = csr_data;
         phase_in = upc_pkg::PH_IDLE;
         high_in  = 6'd0;
      end else if (accept) begin
         if (mode_ff != upc_pkg::MODE_DECODE) begin
            phase_in = upc_pkg::PH_IDLE;
            high_in  = 6'd0;
         end else begin
            case (phase_ff)
               upc_pkg::PH_IDLE: begin
                  if (req_in_byte == upc_pkg::CH_PCT) phase_in = upc_pkg::PH_PCT;
               end
               upc_pkg::PH_PCT: begin
                  // a second '%' stays the pending opener
                  if (req_in_byte != upc_pkg::CH_PCT) begin
                     high_in  = hi_new;
                     phase_in = upc_pkg::PH_DIGIT;
                  end
               end
               default: begin
                  phase_in = upc_pkg::PH_IDLE;
                  high_in  = 6'd0;
               end
            endcase
            if (req_msg_last) begin
               phase_in = upc_pkg::PH_IDLE;
               high_in  = 6'd0;
            end
         end
      end
   end

   // result group
   always_comb begin
      ent.b0    = req_in_byte;
      ent.b1    = 8'd0;
      ent.b2    = 8'd0;
      ent.count = 2'd1;
      ent.last  = req_msg_last;
      if (mode_ff == upc_pkg::MODE_DECODE) begin
         case (phase_ff)
            upc_pkg::PH_IDLE: begin
               if (req_in_byte == upc_pkg::CH_PCT) begin
                  // cut-off escape yields the bad-digit byte
                  ent.b0    = combine(6'd0, upc_pkg::BAD_LOW);
                  ent.count = req_msg_last ? 2'd1 : 2'd0;
               end else if (req_in_byte == upc_pkg::CH_PLUS) begin
                  ent.b0 = upc_pkg::CH_SPACE;
               end
            end
            upc_pkg::PH_PCT: begin
               if (req_in_byte == upc_pkg::CH_PCT) begin
                  ent.b0    = upc_pkg::CH_PCT;
                  ent.b1    = combine(6'd0, upc_pkg::BAD_LOW);
                  ent.count = req_msg_last ? 2'd2 : 2'd1;
               end else begin
                  ent.b0    = combine(hi_new, upc_pkg::BAD_LOW);
                  ent.count = req_msg_last ? 2'd1 : 2'd0;
               end
            end
            default: begin
               ent.b0 = combine(high_ff, dig_ok ? dig_val : upc_pkg::BAD_LOW);
            end
         endcase
      end else if (!pass) begin
         if (req_in_byte == upc_pkg::CH_SPACE) begin
            ent.b0 = upc_pkg::CH_PLUS;
         end else begin
            ent.b0    = upc_pkg::CH_PCT;
            ent.b1    = hex_char(req_in_byte[7:4]);
            ent.b2    = hex_char(req_in_byte[3:0]);
            ent.count = 2'd3;
         end
      end
   end

   assign q_push  = accept & (ent.count != 2'd0);
   assign q_entry = ent;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= upc_pkg::PH_IDLE;
         high_ff  <= 6'd0;
         mode_ff  <= upc_pkg::MODE_DECODE;
      end else begin
         phase_ff <= phase_in;
         high_ff  <= high_in;
         mode_ff  <= mode_in;
      end
   end

endmodule

// File: design/upc_queue.sv
// Short queue of result groups between front and back.
module upc_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  upc_pkg::upc_entry_type push_entry,
   output logic                   full,
   input  logic                   pop,
   output logic                   head_valid,
   output upc_pkg::upc_entry_type head_entry
);

   upc_pkg::upc_entry_type         mem_ff [upc_pkg::QDEPTH];
   logic [upc_pkg::QPTR_W-1:0]     wr_ff, wr_in;
   logic [upc_pkg::QPTR_W-1:0]     rd_ff, rd_in;
   logic [upc_pkg::QCNT_W-1:0]     fill_ff, fill_in;
   logic                           do_pop;

   assign full       = (fill_ff == upc_pkg::QCNT_W'(upc_pkg::QDEPTH));
   assign head_valid = (fill_ff != '0);
   assign head_entry = mem_ff[rd_ff];
   assign do_pop     = pop & head_valid;

   always_comb begin
      wr_in   = push ? wr_ff + 1'b1 : wr_ff;
      rd_in   = do_pop ? rd_ff + 1'b1 : rd_ff;
      fill_in = fill_ff;
      if (push && !do_pop) fill_in = fill_ff + 1'b1;
      else if (!push && do_pop) fill_in = fill_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

endmodule

// File: design/upc_back.sv
// Back end: serialises queued result groups into the output register.
module upc_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   head_valid,
   input  upc_pkg::upc_entry_type head_entry,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_run_last,
   output logic                   rsp_msg_end
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       run_ff, run_in;
   logic       end_ff, end_in;
   logic       load_ok;
   logic       load;
   logic       final_byte;

   assign load_ok    = ~valid_ff | ~rsp_stall;
   assign load       = load_ok & head_valid;
   assign final_byte = (idx_ff == head_entry.count - 2'd1);
   assign pop        = load & final_byte;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      run_in   = run_ff;
      end_in   = end_ff;
      if (load) begin
         valid_in = 1'b1;
         case (idx_ff)
            2'd0:    byte_in = head_entry.b0;
            2'd1:    byte_in = head_entry.b1;
            default: byte_in = head_entry.b2;
         endcase
         run_in = final_byte;
         end_in = final_byte & head_entry.last;
         idx_in = final_byte ? 2'd0 : idx_ff + 2'd1;
      end else if (load_ok) begin
         // result taken, nothing to follow
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      run_ff  <= run_in;
      end_ff  <= end_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_run_last = run_ff;
   assign rsp_msg_end  = end_ff;

endmodule

// File: design/url_percent_codec.sv
// Top level of the URL percent codec: front end, queue and back end.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | req_in_byte, req_msg_last
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_out_byte, rsp_run_last, rsp_msg_end
//   csr     | in        | csr_valid/csr_ready  | csr_data (codec_mode)
//
// The back end sends one result byte per cycle while rsp_stall is low; an escaped
// byte in encode yields three result bytes.
// A result passes through the queue and then the output register on its way to rsp.
// The front end takes a new transaction every cycle while the four-entry queue
// has room; rsp_stall backs up the queue and then raises req_stall.
// Synchronous reset clears the escape state, codec_mode, the queue and rsp_valid.
module url_percent_codec (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_msg_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_msg_end,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_data
);

   logic                   q_full;
   logic                   q_push;
   upc_pkg::upc_entry_type q_entry;
   logic                   q_pop;
   logic                   q_head_valid;
   upc_pkg::upc_entry_type q_head;

   upc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_byte  (req_in_byte),
      .req_msg_last (req_msg_last),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_entry      (q_entry)
   );

   upc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_entry (q_head)
   );

   upc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (q_head_valid),
      .head_entry   (q_head),
      .pop          (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_run_last (rsp_run_last),
      .rsp_msg_end  (rsp_msg_end)
   );

endmodule
